/* src/lpwe_pkg.sv */
// Package for the LED pulse width encoder: item types, register codes and
// reset values. It has no dependencies; every module of the block uses it.
package lpwe_pkg;

  localparam int unsigned DataW       = 8;
  localparam int unsigned ShortW      = 8;
  localparam int unsigned GapW        = 16;
  localparam int unsigned TicksW      = 16;
  localparam int unsigned SegW        = 5;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [ShortW-1:0] ResetShortTicks = 8'd20;
  localparam logic [ShortW-1:0] ResetLongTicks  = 8'd43;
  localparam logic [GapW-1:0]   ResetGapTicks   = 16'd4000;

  // Segment numbers: 0..15 are the bit segments, 16 is the latch gap.
  localparam logic [SegW-1:0] SegLastBit = 5'd15;
  localparam logic [SegW-1:0] SegLatch   = 5'd16;

  localparam int unsigned DefaultQueueDepth = 2;

  typedef enum logic [CfgIndexW-1:0] {
    CfgShortTicks = 2'd0,
    CfgLongTicks  = 2'd1,
    CfgGapTicks   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             last_byte;
    logic             chain_select;
  } in_item_t;

  typedef struct packed {
    logic              line_level;
    logic [TicksW-1:0] segment_ticks;
    logic              chain_out;
    logic              run_end;
  } res_item_t;

  // Queue entry: the input word plus the number of its final segment.
  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             chain_select;
    logic [SegW-1:0]  last_seg;
  } entry_t;

  // Segment durations, already forced to at least one tick.
  typedef struct packed {
    logic [ShortW-1:0] short_ticks;
    logic [ShortW-1:0] long_ticks;
    logic [GapW-1:0]   gap_ticks;
  } timing_t;

endpackage

/* src/lpwe_cfg.sv */
// Configuration registers of the LED pulse width encoder.
// Depends on lpwe_pkg; delivers the durations as lpwe_pkg::timing_t.
module lpwe_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lpwe_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [lpwe_pkg::CfgDataW-1:0]  cfg_data_i,
  output lpwe_pkg::timing_t              timing_o
);

  logic [lpwe_pkg::ShortW-1:0] short_q, short_d;
  logic [lpwe_pkg::ShortW-1:0] long_q, long_d;
  logic [lpwe_pkg::GapW-1:0]   gap_q, gap_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    short_d = short_q;
    long_d  = long_q;
    gap_d   = gap_q;
    if (cfg_valid_i) begin
      unique case (lpwe_pkg::cfg_reg_e'(cfg_index_i))
        lpwe_pkg::CfgShortTicks: short_d = cfg_data_i[lpwe_pkg::ShortW-1:0];
        lpwe_pkg::CfgLongTicks:  long_d  = cfg_data_i[lpwe_pkg::ShortW-1:0];
        lpwe_pkg::CfgGapTicks:   gap_d   = cfg_data_i[lpwe_pkg::GapW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= lpwe_pkg::ResetShortTicks;
      long_q  <= lpwe_pkg::ResetLongTicks;
      gap_q   <= lpwe_pkg::ResetGapTicks;
    end else begin
      short_q <= short_d;
      long_q  <= long_d;
      gap_q   <= gap_d;
    end
  end

  // A duration of zero is sent as one tick.
  assign timing_o.short_ticks = (short_q == '0) ? 8'd1 : short_q;
  assign timing_o.long_ticks  = (long_q == '0) ? 8'd1 : long_q;
  assign timing_o.gap_ticks   = (gap_q == '0) ? 16'd1 : gap_q;

endmodule

/* src/lpwe_front.sv */
// Front end of the LED pulse width encoder: takes input words, tags each
// with its final segment number and holds them in a short queue.
// Depends on lpwe_pkg.
module lpwe_front #(
  parameter int unsigned QueueDepth = lpwe_pkg::DefaultQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  lpwe_pkg::in_item_t  in_data_i,
  output logic                deq_valid_o,
  output lpwe_pkg::entry_t    deq_data_o,
  input  logic                deq_pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  lpwe_pkg::entry_t mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;
  lpwe_pkg::entry_t new_entry;

  assign busy_o      = (count_q == CntFull);
  assign push        = start_i && !busy_o;
  assign deq_valid_o = (count_q != '0);
  assign pop         = deq_pop_i && deq_valid_o;
  assign deq_data_o  = mem_q[rd_ptr_q];

  // A frame-ending word carries one more segment, the latch gap.
  always_comb begin
    new_entry.data_byte    = in_data_i.data_byte;
    new_entry.chain_select = in_data_i.chain_select;
    new_entry.last_seg     = in_data_i.last_byte ? lpwe_pkg::SegLatch
                                                 : lpwe_pkg::SegLastBit;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_entry;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("queue count exceeds depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on push");
`endif

endmodule

/* src/lpwe_back.sv */
// Back end of the LED pulse width encoder: walks one queued word through
// its line segments, one segment per cycle, into a result register.
// Depends on lpwe_pkg and the durations from lpwe_cfg.
module lpwe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpwe_pkg::timing_t   timing_i,
  input  logic                deq_valid_i,
  input  lpwe_pkg::entry_t    deq_data_i,
  output logic                deq_pop_o,
  output logic                res_valid_o,
  output lpwe_pkg::res_item_t res_data_o
);

  logic                          act_q, act_d;
  logic [lpwe_pkg::SegW-1:0]     seg_q, seg_d;
  lpwe_pkg::entry_t              ent_q, ent_d;
  logic                          res_valid_q;
  lpwe_pkg::res_item_t           res_q, seg_item;
  logic                          final_seg;
  logic                          is_latch;
  logic                          bit_val;
  logic                          high_half;
  logic                          use_long;

  assign final_seg = act_q && (seg_q == ent_q.last_seg);
  assign deq_pop_o = (!act_q || final_seg) && deq_valid_i;

  always_comb begin
    act_d = act_q;
    seg_d = seg_q;
    ent_d = ent_q;
    if (act_q) begin
      seg_d = seg_q + 1'b1;
    end
    // The next word is loaded in the same cycle as the final segment goes out.
    if (!act_q || final_seg) begin
      if (deq_valid_i) begin
        act_d = 1'b1;
        ent_d = deq_data_i;
        seg_d = '0;
      end else begin
        act_d = 1'b0;
      end
    end
  end

  // Even segments are the high half of a bit, odd ones the low half.
  always_comb begin
    is_latch  = seg_q[lpwe_pkg::SegW-1];
    bit_val   = ent_q.data_byte[~seg_q[3:1]];
    high_half = !seg_q[0];
    use_long  = high_half ? bit_val : !bit_val;
    seg_item.line_level    = high_half && !is_latch;
    seg_item.segment_ticks = is_latch ? timing_i.gap_ticks
                           : {8'd0, (use_long ? timing_i.long_ticks
                                              : timing_i.short_ticks)};
    seg_item.chain_out     = ent_q.chain_select;
    seg_item.run_end       = final_seg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      seg_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      act_q       <= act_d;
      seg_q       <= seg_d;
      res_valid_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (act_q) begin
      res_q <= seg_item;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_q;

`ifndef SYNTHESIS
  a_end_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_seg |=> (res_valid_q && res_q.run_end))
    else $error("final segment not marked as run end");

  a_word_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.run_end) |-> act_q)
    else $error("word dropped before its final segment");

  a_seg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (seg_q <= ent_q.last_seg))
    else $error("segment counter ran past the final segment");
`endif

endmodule

/* src/led_pulse_width_encoder_unit.sv */
// Top level of the LED pulse width encoder: configuration registers, a
// front end with its word queue and a segment back end. Depends on lpwe_pkg.
//
//   channel   handshake               payload
//   input     start / busy            in_data_i  (lpwe_pkg::in_item_t)
//   result    res_valid_o (strobe)    res_data_o (lpwe_pkg::res_item_t)
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each word yields 16 results, 17 with last_byte set, one per cycle; the
// back end's segment counter sets this rate and queued words follow without gaps.
// With the back end idle, a word's first result follows the queue, word and
// result registers; otherwise it follows the previous word's last result.
// busy rises only when the word queue is full; the receiver cannot stall.
// Reset clears the queue and restores the register reset values.
module led_pulse_width_encoder_unit #(
  parameter int unsigned QueueDepth = lpwe_pkg::DefaultQueueDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  lpwe_pkg::in_item_t             in_data_i,
  output logic                           res_valid_o,
  output lpwe_pkg::res_item_t            res_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lpwe_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [lpwe_pkg::CfgDataW-1:0]  cfg_data_i
);

  lpwe_pkg::timing_t timing;
  logic              deq_valid;
  logic              deq_pop;
  lpwe_pkg::entry_t  deq_data;

  lpwe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .timing_o    (timing)
  );

  lpwe_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .in_data_i   (in_data_i),
    .deq_valid_o (deq_valid),
    .deq_data_o  (deq_data),
    .deq_pop_i   (deq_pop)
  );

  lpwe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timing_i    (timing),
    .deq_valid_i (deq_valid),
    .deq_data_i  (deq_data),
    .deq_pop_o   (deq_pop),
    .res_valid_o (res_valid_o),
    .res_data_o  (res_data_o)
  );

endmodule
